// ===== rtl/core/mma_pkg.sv =====
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, register codes, reset values and types of the Mobius and
// Mertens accumulator.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 16;

   localparam int WINDOW_WIDTH = 16;
   localparam int SUM_WIDTH    = 16;
   localparam int COUNT_WIDTH  = 16;
   localparam int MOBIUS_WIDTH = 2;
   localparam int FACTOR_COUNT_WIDTH = 5;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_LOW  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_HIGH = 1'd1;

   localparam logic [WINDOW_WIDTH-1:0] WINDOW_LOW_RESET  = 16'd9991;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_HIGH_RESET = 16'd10009;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = 16'sh7FFF;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = 16'sh8000;

   typedef logic signed [MOBIUS_WIDTH-1:0] mobius_type;

   localparam mobius_type MOBIUS_ZERO  = 2'sb00;
   localparam mobius_type MOBIUS_PLUS  = 2'sb01;
   localparam mobius_type MOBIUS_MINUS = 2'sb11;

   typedef struct packed {
      logic       valid;
      mobius_type mobius;
   } factor_rsp_type;

endpackage

// ===== rtl/core/mma_req_if.sv =====
// ----------------------------------------------------------------------------
// mma_req_if
// Input channel: one number to classify and its restart flag per item.
// ----------------------------------------------------------------------------
interface mma_req_if import mma_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) ();

   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] number;
   logic                    restart;

   modport source (output valid, output number, output restart, input ready);
   modport sink (input valid, input number, input restart, output ready);

endinterface

// ===== rtl/core/mma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mma_rsp_if
// Result channel: the Mobius value, running sum and zero count per item.
// ----------------------------------------------------------------------------
interface mma_rsp_if import mma_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) ();

   logic                          valid;
   logic                          ready;
   logic [NUMBER_WIDTH-1:0]       echo_number;
   mobius_type                    mobius_value;
   logic signed [SUM_WIDTH-1:0]   mertens_sum;
   logic [COUNT_WIDTH-1:0]        zero_points;
   logic                          in_window;

   modport source (output valid, output echo_number, output mobius_value,
                   output mertens_sum, output zero_points, output in_window,
                   input ready);
   modport sink (input valid, input echo_number, input mobius_value,
                 input mertens_sum, input zero_points, input in_window,
                 output ready);

endinterface

// ===== rtl/core/mma_div.sv =====
// ----------------------------------------------------------------------------
// mma_div
// Restoring divider that produces one quotient bit per cycle and is shared
// by every trial division of the factoring sequencer.
// ----------------------------------------------------------------------------
module mma_div import mma_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic                    done,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder
);

   localparam int STEP_WIDTH = $clog2(NUMBER_WIDTH);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NUMBER_WIDTH - 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quot_ff, quot_in;
   logic [NUMBER_WIDTH-1:0] dvsr_ff, dvsr_in;
   logic [NUMBER_WIDTH:0]   shifted;
   logic [NUMBER_WIDTH:0]   diff;

   assign shifted = {rem_ff, quot_ff[NUMBER_WIDTH-1]};
   assign diff    = shifted - {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = LAST_STEP;
         rem_in  = '0;
         quot_in = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         if (diff[NUMBER_WIDTH]) begin
            rem_in  = shifted[NUMBER_WIDTH-1:0];
            quot_in = {quot_ff[NUMBER_WIDTH-2:0], 1'b0};
         end else begin
            rem_in  = diff[NUMBER_WIDTH-1:0];
            quot_in = {quot_ff[NUMBER_WIDTH-2:0], 1'b1};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/mma_factor.sv =====
// ----------------------------------------------------------------------------
// mma_factor
// Trial division sequencer: walks divisors from two upward through the
// shared divider and yields the Mobius value of one number.
// ----------------------------------------------------------------------------
module mma_factor import mma_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] number,
   input  logic                    ack,
   output factor_rsp_type          rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV1 = 2'd1;
   localparam logic [1:0] S_DIV2 = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [NUMBER_WIDTH-1:0] FIRST_DIVISOR = NUMBER_WIDTH'(2);
   localparam logic [NUMBER_WIDTH-1:0] ONE = NUMBER_WIDTH'(1);

   logic [1:0]                    state_ff, state_in;
   logic [NUMBER_WIDTH-1:0]       trial_divisor_ff, trial_divisor_in;
   logic [NUMBER_WIDTH-1:0]       remaining_value_ff, remaining_value_in;
   logic [FACTOR_COUNT_WIDTH-1:0] prime_factor_count_ff, prime_factor_count_in;
   logic                          square_found_ff, square_found_in;
   mobius_type                    mobius_ff, mobius_in;

   logic                    div_start;
   logic [NUMBER_WIDTH-1:0] div_dividend;
   logic [NUMBER_WIDTH-1:0] div_divisor;
   logic                    div_done;
   logic [NUMBER_WIDTH-1:0] div_quotient;
   logic [NUMBER_WIDTH-1:0] div_remainder;

   logic [NUMBER_WIDTH-1:0]       next_divisor;
   logic [FACTOR_COUNT_WIDTH-1:0] final_count;

   mma_div #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   assign next_divisor = trial_divisor_ff + 1'b1;
   assign final_count  = (remaining_value_ff > ONE) ? prime_factor_count_ff + 1'b1
                                                    : prime_factor_count_ff;

   always_comb begin
      state_in              = state_ff;
      trial_divisor_in      = trial_divisor_ff;
      remaining_value_in    = remaining_value_ff;
      prime_factor_count_in = prime_factor_count_ff;
      square_found_in       = square_found_ff;
      mobius_in             = mobius_ff;
      div_start             = 1'b0;
      div_dividend          = remaining_value_ff;
      div_divisor           = trial_divisor_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               trial_divisor_in      = FIRST_DIVISOR;
               remaining_value_in    = number;
               prime_factor_count_in = '0;
               square_found_in       = 1'b0;
               if (number == '0) begin
                  square_found_in = 1'b1;
                  mobius_in       = MOBIUS_ZERO;
                  state_in        = S_DONE;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = number;
                  div_divisor  = FIRST_DIVISOR;
                  state_in     = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            if (div_done) begin
               if (div_quotient < trial_divisor_ff) begin
                  // The divisor has passed the square root of what is left.
                  prime_factor_count_in = final_count;
                  if (remaining_value_ff > ONE) begin
                     remaining_value_in = ONE;
                  end
                  mobius_in = final_count[0] ? MOBIUS_MINUS : MOBIUS_PLUS;
                  state_in  = S_DONE;
               end else if (div_remainder == '0) begin
                  remaining_value_in = div_quotient;
                  div_start          = 1'b1;
                  div_dividend       = div_quotient;
                  state_in           = S_DIV2;
               end else begin
                  trial_divisor_in = next_divisor;
                  div_start        = 1'b1;
                  div_divisor      = next_divisor;
               end
            end
         end
         S_DIV2: begin
            if (div_done) begin
               if (div_remainder == '0) begin
                  square_found_in = 1'b1;
                  mobius_in       = MOBIUS_ZERO;
                  state_in        = S_DONE;
               end else begin
                  prime_factor_count_in = prime_factor_count_ff + 1'b1;
                  trial_divisor_in      = next_divisor;
                  div_start             = 1'b1;
                  div_divisor           = next_divisor;
                  state_in              = S_DIV1;
               end
            end
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff              <= S_IDLE;
         trial_divisor_ff      <= FIRST_DIVISOR;
         remaining_value_ff    <= '0;
         prime_factor_count_ff <= '0;
         square_found_ff       <= 1'b0;
      end else begin
         state_ff              <= state_in;
         trial_divisor_ff      <= trial_divisor_in;
         remaining_value_ff    <= remaining_value_in;
         prime_factor_count_ff <= prime_factor_count_in;
         square_found_ff       <= square_found_in;
      end
      mobius_ff <= mobius_in;
   end

   assign rsp.valid  = (state_ff == S_DONE);
   assign rsp.mobius = square_found_ff ? MOBIUS_ZERO : mobius_ff;

endmodule

// ===== rtl/core/mobius_mertens_accumulator.sv =====
// ----------------------------------------------------------------------------
// mobius_mertens_accumulator
// Each item carries one number; the block finds its Mobius value by trial
// division with a shared one-bit-per-cycle divider, adds it to a saturating
// running Mertens sum and counts the items after which that sum is zero. One
// item is taken at a time. A number n needs about sqrt(n) trial divisions
// plus one more for each prime factor found, and zero needs none. A finished
// result waits in the output register while the next item is taken. The
// window registers may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module mobius_mertens_accumulator import mma_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   mma_req_if.sink                    req_chan,
   mma_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int CMP_WIDTH = (NUMBER_WIDTH > WINDOW_WIDTH) ? NUMBER_WIDTH : WINDOW_WIDTH;

   logic [WINDOW_WIDTH-1:0]      window_low_ff, window_low_in;
   logic [WINDOW_WIDTH-1:0]      window_high_ff, window_high_in;
   logic                         busy_ff, busy_in;
   logic [NUMBER_WIDTH-1:0]      number_ff;
   logic                         restart_ff;
   logic signed [SUM_WIDTH-1:0]  running_sum_ff, running_sum_in;
   logic [COUNT_WIDTH-1:0]       zero_counter_ff, zero_counter_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_WIDTH-1:0]      rsp_number_ff;
   mobius_type                   rsp_mobius_ff;
   logic                         rsp_window_ff;

   factor_rsp_type               fac_rsp;
   logic                         accept;
   logic                         ack;
   logic signed [SUM_WIDTH-1:0]  base_sum;
   logic [COUNT_WIDTH-1:0]       base_count;
   logic signed [SUM_WIDTH:0]    wide_sum;
   logic signed [SUM_WIDTH-1:0]  new_sum;
   logic [CMP_WIDTH-1:0]         cmp_number;
   logic                         window_hit;

   assign accept = req_chan.valid && req_chan.ready;
   assign ack    = fac_rsp.valid && (!rsp_valid_ff || rsp_chan.ready);

   mma_factor #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_factor (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .number (req_chan.number),
      .ack    (ack),
      .rsp    (fac_rsp)
   );

   always_comb begin
      window_low_in  = window_low_ff;
      window_high_in = window_high_ff;
      if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LOW:  window_low_in  = csr_wdata[WINDOW_WIDTH-1:0];
            REG_WINDOW_HIGH: window_high_in = csr_wdata[WINDOW_WIDTH-1:0];
            default: begin
               window_low_in = window_low_ff;
            end
         endcase
      end
   end

   assign base_sum   = restart_ff ? '0 : running_sum_ff;
   assign base_count = restart_ff ? '0 : zero_counter_ff;
   assign wide_sum   = {base_sum[SUM_WIDTH-1], base_sum}
                     + {{(SUM_WIDTH - 1){fac_rsp.mobius[MOBIUS_WIDTH-1]}}, fac_rsp.mobius};

   always_comb begin
      if (wide_sum[SUM_WIDTH] != wide_sum[SUM_WIDTH-1]) begin
         new_sum = wide_sum[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         new_sum = wide_sum[SUM_WIDTH-1:0];
      end
   end

   assign cmp_number = CMP_WIDTH'(number_ff);
   assign window_hit = (cmp_number >= CMP_WIDTH'(window_low_ff))
                    && (cmp_number <= CMP_WIDTH'(window_high_ff));

   always_comb begin
      busy_in         = busy_ff;
      running_sum_in  = running_sum_ff;
      zero_counter_in = zero_counter_ff;
      rsp_valid_in    = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (ack) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         running_sum_in = new_sum;
         if ((new_sum == '0) && (base_count != '1)) begin
            zero_counter_in = base_count + 1'b1;
         end else begin
            zero_counter_in = base_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff   <= WINDOW_LOW_RESET;
         window_high_ff  <= WINDOW_HIGH_RESET;
         busy_ff         <= 1'b0;
         running_sum_ff  <= '0;
         zero_counter_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_low_ff   <= window_low_in;
         window_high_ff  <= window_high_in;
         busy_ff         <= busy_in;
         running_sum_ff  <= running_sum_in;
         zero_counter_ff <= zero_counter_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      if (accept) begin
         number_ff  <= req_chan.number;
         restart_ff <= req_chan.restart;
      end
      if (ack) begin
         rsp_number_ff <= number_ff;
         rsp_mobius_ff <= fac_rsp.mobius;
         rsp_window_ff <= window_hit;
      end
   end

   assign req_chan.ready        = !busy_ff;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.echo_number  = rsp_number_ff;
   assign rsp_chan.mobius_value = rsp_mobius_ff;
   assign rsp_chan.mertens_sum  = running_sum_ff;
   assign rsp_chan.zero_points  = zero_counter_ff;
   assign rsp_chan.in_window    = rsp_window_ff;

endmodule

// ===== tb/sv/tb_mobius_mertens_accumulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mobius_mertens_accumulator
// Self-checking bench for the Mobius and Mertens accumulator. A scoreboard
// recomputes each item's Mobius value by trial division, keeps its own running
// sum, zero count and window registers, and checks every result field by
// field. Directed numbers, counting runs from one, random numbers, window
// changes and long receiver stalls exercise the block.
// ----------------------------------------------------------------------------
module tb_mobius_mertens_accumulator import mma_pkg::*; ();

   localparam int NUMBER_BITS = 16;
   localparam int RANDOM_ITEMS = 560;
   localparam int CHUNKS = 8;
   localparam longint CYCLE_LIMIT = 20_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int END_CYCLES = 200;
   localparam int REPORT_LIMIT = 100;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [NUMBER_BITS-1:0]      echo_number;
      mobius_type                  mobius_value;
      logic signed [SUM_WIDTH-1:0] mertens_sum;
      logic [COUNT_WIDTH-1:0]      zero_points;
      logic                        in_window;
   } mertens_result_type;

   class mertens_scoreboard_type;
      logic [WINDOW_WIDTH-1:0] window_low;
      logic [WINDOW_WIDTH-1:0] window_high;
      int                      running_sum;
      int                      zero_count;
      int                      error_count;
      mertens_result_type      pending_results[$];

      function new();
         window_low = WINDOW_LOW_RESET;
         window_high = WINDOW_HIGH_RESET;
         running_sum = 0;
         zero_count = 0;
         error_count = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            REG_WINDOW_LOW: window_low = value;
            REG_WINDOW_HIGH: window_high = value;
            default: ;
         endcase
      endfunction

      // Zero is divisible by every square, so it yields zero.
      function int mobius_by_division(logic [NUMBER_BITS-1:0] n);
         longint unsigned divisor;
         longint unsigned rest;
         int              factors;
         if (n == 0) return 0;
         divisor = 2;
         rest = n;
         factors = 0;
         while (divisor * divisor <= rest) begin
            if (rest % divisor == 0) begin
               rest = rest / divisor;
               if (rest % divisor == 0) return 0;
               factors++;
            end
            divisor++;
         end
         if (rest > 1) factors++;
         return (factors % 2 == 1) ? -1 : 1;
      endfunction

      function void note_number(logic [NUMBER_BITS-1:0] n, logic restart);
         mertens_result_type want;
         int                 mu;
         int                 total;
         if (restart) begin
            running_sum = 0;
            zero_count = 0;
         end
         mu = mobius_by_division(n);
         total = running_sum + mu;
         if (total > int'(SUM_MAX)) total = int'(SUM_MAX);
         if (total < int'(SUM_MIN)) total = int'(SUM_MIN);
         running_sum = total;
         if (running_sum == 0 && zero_count < 65535) zero_count++;
         want.echo_number = n;
         want.mobius_value = (mu > 0) ? MOBIUS_PLUS : ((mu < 0) ? MOBIUS_MINUS : MOBIUS_ZERO);
         want.mertens_sum = SUM_WIDTH'(running_sum);
         want.zero_points = COUNT_WIDTH'(zero_count);
         want.in_window = (n >= window_low && n <= window_high);
         pending_results.push_back(want);
      endfunction

      function void compare_field(string field, logic [NUMBER_BITS-1:0] n,
                                  logic signed [31:0] want, logic signed [31:0] got);
         if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: number %0d %s mismatch, expected %0d, actual %0d",
                        $time, n, field, want, got);
         end
      endfunction

      function void check_result(mertens_result_type got);
         mertens_result_type want;
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected result, expected none, actual number %0d",
                        $time, got.echo_number);
            return;
         end
         want = pending_results.pop_front();
         compare_field("echo_number", want.echo_number, want.echo_number, got.echo_number);
         compare_field("mobius_value", want.echo_number, want.mobius_value, got.mobius_value);
         compare_field("mertens_sum", want.echo_number, want.mertens_sum, got.mertens_sum);
         compare_field("zero_points", want.echo_number, want.zero_points, got.zero_points);
         compare_field("in_window", want.echo_number, want.in_window, got.in_window);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   logic                       hold_ready;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   longint                     cycle_count = 0;
   mertens_scoreboard_type     board = new();

   mma_req_if #(.NUMBER_WIDTH(NUMBER_BITS)) req_bus ();
   mma_rsp_if #(.NUMBER_WIDTH(NUMBER_BITS)) rsp_bus ();

   mobius_mertens_accumulator #(.NUMBER_WIDTH(NUMBER_BITS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_ready) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      mertens_result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.note_number(req_bus.number, req_bus.restart);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.echo_number = rsp_bus.echo_number;
            got.mobius_value = rsp_bus.mobius_value;
            got.mertens_sum = rsp_bus.mertens_sum;
            got.zero_points = rsp_bus.zero_points;
            got.in_window = rsp_bus.in_window;
            board.check_result(got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_mobius_mertens_accumulator failed");
         $finish;
      end
   end

   task automatic send_number(input logic [NUMBER_BITS-1:0] number, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.number <= number;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WINDOW_WIDTH-1:0] low,
                               input logic [WINDOW_WIDTH-1:0] high);
      csr_we <= 1'b1;
      csr_index <= REG_WINDOW_LOW;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= REG_WINDOW_HIGH;
      csr_wdata <= high;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      board.write_register(REG_WINDOW_LOW, low);
      board.write_register(REG_WINDOW_HIGH, high);
   endtask

   task automatic hold_receiver(input int cycles);
      fork
         begin
            hold_ready <= 1'b1;
            repeat (cycles) @(posedge clock);
            hold_ready <= 1'b0;
         end
      join_none
   endtask

   // Most items form counting runs from one so that the sum follows the Mertens
   // function; the rest are short runs, scattered, large or on the window edges.
   task automatic send_random_items(input int count);
      int                     sent;
      int                     pick;
      int                     length;
      int                     start;
      logic [NUMBER_BITS-1:0] n;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            length = $urandom_range(40, 4);
            for (int k = 1; k <= length && sent < count; k++) begin
               send_number(NUMBER_BITS'(k), k == 1);
               sent++;
            end
         end else if (pick < 70) begin
            start = $urandom_range(2000, 2);
            length = $urandom_range(15, 3);
            for (int k = 0; k < length && sent < count; k++) begin
               send_number(NUMBER_BITS'(start + k), 1'b0);
               sent++;
            end
         end else if (pick < 78) begin
            send_number(NUMBER_BITS'($urandom_range(65535)), 1'($urandom_range(1)));
            sent++;
         end else if (pick < 84) begin
            case ($urandom_range(3))
               0: n = board.window_low;
               1: n = board.window_high;
               2: n = board.window_low - 1'b1;
               default: n = board.window_high + 1'b1;
            endcase
            send_number(n, 1'b0);
            sent++;
         end else begin
            send_number(NUMBER_BITS'($urandom_range(1023)), $urandom_range(99) < 10);
            sent++;
         end
      end
   endtask

   initial begin
      logic [WINDOW_WIDTH-1:0] low;
      logic [WINDOW_WIDTH-1:0] high;
      int                      half;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.number = '0;
      req_bus.restart = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_WINDOW_LOW;
      csr_wdata = '0;
      hold_ready = 1'b0;
      send_idle_pct = 19;
      recv_idle_pct = 79;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_number(16'd0, 1'b1);
      send_number(16'd1, 1'b0);
      send_number(16'd2, 1'b0);
      send_number(16'd3, 1'b0);
      send_number(16'd4, 1'b0);
      send_number(16'd9, 1'b0);
      send_number(16'd6, 1'b0);
      send_number(16'd30, 1'b0);
      send_number(16'd210, 1'b0);
      send_number(16'd2310, 1'b0);
      send_number(16'd49, 1'b1);
      send_number(16'd25, 1'b0);
      send_number(16'd9990, 1'b0);
      send_number(16'd9991, 1'b0);
      send_number(16'd10009, 1'b0);
      send_number(16'd10010, 1'b0);
      send_number(16'd32768, 1'b0);
      send_number(16'd65521, 1'b0);
      send_number(16'd65534, 1'b0);
      send_number(16'd65535, 1'b1);
      wait_for_results();

      half = RANDOM_ITEMS / CHUNKS / 2;
      for (int c = 0; c < CHUNKS; c++) begin
         if (c == 3) begin
            send_idle_pct = 79;
            recv_idle_pct = 19;
         end else if (c == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (c)
            0: begin low = 16'd1; high = 16'd1; end
            1, 5: begin
               low = WINDOW_WIDTH'($urandom_range(100));
               high = low + WINDOW_WIDTH'($urandom_range(60));
            end
            2: begin low = 16'd65535; high = 16'd65535; end
            3: begin low = 16'd0; high = 16'd65535; end
            4: begin low = 16'd200; high = 16'd100; end
            6: begin low = 16'd65535; high = 16'd0; end
            default: begin
               low = WINDOW_WIDTH'($urandom_range(2000));
               high = low + WINDOW_WIDTH'($urandom_range(3000));
            end
         endcase
         write_window(low, high);
         if (c == 1 || c == 4) hold_receiver(HOLD_CYCLES);
         send_random_items(half);
         if (c == 2) wait_for_results();
         send_random_items(RANDOM_ITEMS / CHUNKS - half);
         wait_for_results();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("tb_mobius_mertens_accumulator passed");
      end else begin
         $display("tb_mobius_mertens_accumulator failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/mma_pkg.sv
rtl/core/mma_req_if.sv
rtl/core/mma_rsp_if.sv
rtl/core/mma_div.sv
rtl/core/mma_factor.sv
rtl/core/mobius_mertens_accumulator.sv
tb/sv/tb_mobius_mertens_accumulator.sv
